### sv/apfd_pkg.sv
package apfd_pkg;

  // delay line size
  localparam int MAX_DELAY = 1024;
  localparam int RING_LEN  = MAX_DELAY + 2;
  localparam int RING_AW   = $clog2(RING_LEN);

  // field widths
  localparam int SMP_W = 24;
  localparam int DLY_W = 19;

  // delay limits in Q.8
  localparam logic [DLY_W-1:0] DLY_MIN = DLY_W'(128);
  localparam logic [DLY_W-1:0] DLY_MAX = DLY_W'(MAX_DELAY * 256);

  // coefficient divider
  localparam int QUO_W = 16;
  localparam int DEN_W = 10;

  // sample range
  localparam logic signed [SMP_W-1:0] SMP_HI = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_LO = {1'b1, {(SMP_W-1){1'b0}}};

endpackage

### sv/apfd_ram.sv
module apfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/allpass_fractional_delay_unit.sv
// Allpass-interpolated fractional delay line. Each request carries a Q1.23 sample and a
// delay in samples with 8 fraction bits; the delay is held to 0.5 .. MAX_DELAY (flagging
// delay_clamped when lowered), and the result is x[n-D-1] + c*x[n-D] - c*y[n-1] with the
// first-order allpass coefficient c = (f - 0.5)/(2.5 - f) in signed Q0.16, rounded and saturated
// to Q1.23. A new request is held off by in_stall until this one has been finished:
// the coefficient comes from a 16-step restoring divider that runs one quotient bit per
// cycle, followed by a multiply step and a round/saturate step. The history is a
// 1026-entry RAM with one write and one read port; slots never written since reset read
// as zero through a fill count, so there is no clearing pass after reset. A finished
// result waits in the output register while the next request is taken.
module allpass_fractional_delay_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [apfd_pkg::SMP_W-1:0]    sample_in,
  input  logic        [apfd_pkg::DLY_W-1:0]    delay_amount,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [apfd_pkg::SMP_W-1:0]    sample_out,
  output logic                                 delay_clamped
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int AW   = apfd_pkg::RING_AW;
  localparam int SW   = apfd_pkg::SMP_W;
  localparam int QW   = apfd_pkg::QUO_W;
  localparam int NW   = apfd_pkg::DEN_W;
  localparam int PW   = SW + 1 + QW;      // product width
  localparam int ACCW = PW + 2;           // accumulator width

  logic [1:0]          state;
  logic [3:0]          cnt;
  logic [AW-1:0]       write_index;
  logic [AW-1:0]       fill;
  logic [AW-1:0]       base;
  logic [AW-1:0]       dint;
  logic                vd;
  logic                vd1;
  logic                clamped;
  logic                neg;
  logic [NW-1:0]       den;
  logic [NW-1:0]       rem;
  logic [QW-1:0]       quo;
  logic signed [SW-1:0] xd;
  logic signed [SW-1:0] xd1;
  logic signed [SW-1:0] prev_out;
  logic signed [PW-1:0] prod;

  logic                accept;
  logic [apfd_pkg::DLY_W-1:0] dclamp;
  logic                over;
  logic [apfd_pkg::DLY_W-1:0] tsum;
  logic [AW-1:0]       dint_next;
  logic [7:0]          f8;
  logic [8:0]          num;
  logic [7:0]          mag;
  logic [NW-1:0]       den_next;
  logic [23:0]         dividend;
  logic [NW:0]         trial;
  logic                qbit;
  logic [AW-1:0]       kback;
  logic [AW:0]         adiff;
  logic [AW-1:0]       raddr;
  logic [SW-1:0]       rdata;
  logic signed [QW-1:0] coef;
  logic signed [SW:0]  diff;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-17:0] yfull;
  logic signed [SW-1:0] ysat;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // clamp the delay and split it into integer and fraction
  always_comb begin
    over   = (delay_amount > apfd_pkg::DLY_MAX);
    dclamp = delay_amount;
    if (delay_amount < apfd_pkg::DLY_MIN) begin
      dclamp = apfd_pkg::DLY_MIN;
    end
    if (over) begin
      dclamp = apfd_pkg::DLY_MAX;
    end
    tsum      = dclamp + apfd_pkg::DLY_W'(128);
    dint_next = AW'(tsum >> 8);
    f8        = tsum[7:0];
    num       = {1'b0, f8} - 9'd128;
    mag       = num[8] ? 8'(-num) : num[7:0];
    den_next  = NW'(640) - {2'b00, f8};
    dividend  = {mag, 16'h0000} + {15'd0, den_next[NW-1:1]};
  end

  // one restoring divider step
  always_comb begin
    trial = {rem, quo[QW-1]};
    qbit  = (trial >= {1'b0, den});
  end

  // ring address k samples back from this request's slot
  always_comb begin
    kback = (cnt == 4'd0) ? dint : dint + AW'(1);
    adiff = {1'b0, base} - {1'b0, kback};
    if (adiff[AW]) begin
      adiff = adiff + (AW+1)'(apfd_pkg::RING_LEN);
    end
    raddr = adiff[AW-1:0];
  end

  apfd_ram #(
    .WIDTH (SW),
    .DEPTH (apfd_pkg::RING_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (write_index),
    .wdata (sample_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  // coefficient sign, multiply operand, final sum
  always_comb begin
    coef  = neg ? -$signed(quo) : $signed(quo);
    diff  = {xd[SW-1], xd} - {prev_out[SW-1], prev_out};
    acc   = $signed({{3{xd1[SW-1]}}, xd1, 16'h0000})
          + $signed({{2{prod[PW-1]}}, prod})
          + $signed(ACCW'(32768));
    yfull = acc[ACCW-1:16];
    if (yfull > $signed((ACCW-16)'(apfd_pkg::SMP_HI))) begin
      ysat = apfd_pkg::SMP_HI;
    end else if (yfull < $signed({{(ACCW-16-SW){1'b1}}, apfd_pkg::SMP_LO})) begin
      ysat = apfd_pkg::SMP_LO;
    end else begin
      ysat = yfull[SW-1:0];
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      write_index <= '0;
      fill        <= '0;
      prev_out    <= '0;
      out_valid   <= 1'b0;
    end else begin
      // result taken and no new one arriving in its place
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIV;
            cnt   <= '0;
            if (write_index == AW'(apfd_pkg::RING_LEN - 1)) begin
              write_index <= '0;
            end else begin
              write_index <= write_index + AW'(1);
            end
            if (fill != AW'(apfd_pkg::RING_LEN - 1)) begin
              fill <= fill + AW'(1);
            end
          end
        end
        S_DIV: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            prev_out  <= ysat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      base    <= write_index;
      dint    <= dint_next;
      vd      <= (dint_next <= fill);
      vd1     <= (dint_next < fill);
      clamped <= over;
      neg     <= num[8];
      den     <= den_next;
      rem     <= {2'b00, dividend[23:16]};
      quo     <= dividend[15:0];
    end
    if (state == S_DIV) begin
      rem <= qbit ? NW'(trial - {1'b0, den}) : trial[NW-1:0];
      quo <= {quo[QW-2:0], qbit};
      if (cnt == 4'd1) begin
        xd <= vd ? rdata : '0;
      end
      if (cnt == 4'd2) begin
        xd1 <= vd1 ? rdata : '0;
      end
    end
    if (state == S_MUL) begin
      prod <= PW'(coef * diff);
    end
    if (state == S_FIN && out_free) begin
      sample_out    <= ysat;
      delay_clamped <= clamped;
    end
  end

endmodule
